// ===== hdl/bzp_pkg.sv =====
// ---------------------------------------------------------------------------
// bzp_pkg
// Shared types and constants for the Bezier to power-basis converter.
// ---------------------------------------------------------------------------
package bzp_pkg;

  localparam int MaxPoints = 8;
  localparam int CntW      = 4;
  localparam int IdxW      = 3;
  // weighted sums stay well inside 48 bits, division magnitudes inside 47
  localparam int SumW      = 48;
  localparam int MagW      = 47;
  localparam int NumW      = 63;
  localparam logic [MagW-1:0] BigCap = MagW'(64'd1 << 46);

  // binomial coefficient for n up to 7
  function automatic logic [6:0] binom(input logic [2:0] n, input logic [2:0] k);
    logic [6:0] r;
    r = 7'd1;
    unique case ({n, k})
      {3'd2, 3'd1}: r = 7'd2;
      {3'd3, 3'd1}, {3'd3, 3'd2}: r = 7'd3;
      {3'd4, 3'd1}, {3'd4, 3'd3}: r = 7'd4;
      {3'd4, 3'd2}: r = 7'd6;
      {3'd5, 3'd1}, {3'd5, 3'd4}: r = 7'd5;
      {3'd5, 3'd2}, {3'd5, 3'd3}: r = 7'd10;
      {3'd6, 3'd1}, {3'd6, 3'd5}: r = 7'd6;
      {3'd6, 3'd2}, {3'd6, 3'd4}: r = 7'd15;
      {3'd6, 3'd3}: r = 7'd20;
      {3'd7, 3'd1}, {3'd7, 3'd6}: r = 7'd7;
      {3'd7, 3'd2}, {3'd7, 3'd5}: r = 7'd21;
      {3'd7, 3'd3}, {3'd7, 3'd4}: r = 7'd35;
      default: r = 7'd1;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/bzp_divider.sv =====
// ---------------------------------------------------------------------------
// bzp_divider
// Restoring divider, one quotient bit per cycle: (mag*65536 + d/2) / d.
// ---------------------------------------------------------------------------
module bzp_divider import bzp_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  logic [MagW-1:0] mag,
  input  logic [31:0]     divisor,
  output logic            done,
  output logic [MagW-1:0] quot
);

  logic [NumW-1:0] num;
  logic [32:0]     rem;
  logic [5:0]      bits;
  logic            run;
  logic [33:0]     trial;

  // shift in one numerator bit and try subtracting
  assign trial = {rem, num[NumW-1]} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run  <= 1'b1;
        bits <= 6'(NumW);
        rem  <= '0;
        num  <= {mag, 16'd0} + NumW'(divisor >> 1);
      end else if (run) begin
        num <= {num[NumW-2:0], ~trial[33]};
        rem <= trial[33] ? {rem[31:0], num[NumW-1]} : trial[32:0];
        bits <= bits - 6'd1;
        if (bits == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient fits below 2^63; cap at 2^46 to fit the magnitude width
  always_comb begin
    if (num > NumW'(BigCap)) quot = BigCap;
    else quot = num[MagW-1:0];
  end

endmodule

// ===== hdl/bezier_to_power_basis.sv =====
// ---------------------------------------------------------------------------
// bezier_to_power_basis
// Converts Bezier control points to power-basis coefficients, Q16.16.
// ---------------------------------------------------------------------------
// Points load one per request. The request marked last starts the
// conversion: each order j runs a multiply-accumulate over points 0..j on
// one shared 48x8 multiplier, then the outer binomial on the same multiplier,
// then j passes of the bit-serial divider, and then emits the coefficient.
// With zero duration the divider passes are skipped. Busy is high
// throughout the conversion. Each coefficient appears for one cycle with
// strobe high and must be taken then; the receiver cannot stall.
module bezier_to_power_basis import bzp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] point,
  input  logic        [31:0] duration,
  input  logic               last,
  input  logic               empty_req,
  output logic               strobe,
  output logic signed [31:0] coefficient,
  output logic        [2:0]  order,
  output logic               final_res,
  output logic               zero_duration,
  output logic               saturated
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MAC  = 6'b000010,
    S_OUTB = 6'b000100,
    S_DIV  = 6'b001000,
    S_WAIT = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state;
  logic [31:0]           store [MaxPoints];
  logic [CntW-1:0]       count;
  logic [31:0]           held_duration;
  logic [IdxW-1:0]       n, j, i, k;
  logic signed [SumW-1:0] acc;
  logic                  neg;
  logic [MagW-1:0]       mag;
  logic                  div_go, div_done;
  logic [MagW-1:0]       div_q;
  logic                  mid_mode;
  logic signed [SumW-1:0] prod;
  logic signed [SumW-1:0] mac_next;
  logic signed [SumW-1:0] signed_mag;
  logic signed [SumW-1:0] midsum;

  bzp_divider u_div (
    .clk(clk), .rst(rst), .go(div_go), .mag(mag),
    .divisor(held_duration), .done(div_done), .quot(div_q)
  );

  // shared multiplier: term of the inner sum or the outer binomial
  always_comb begin
    if (state == S_OUTB) prod = acc * $signed({1'b0, binom(n, j)});
    else prod = SumW'($signed(store[i])) * $signed({1'b0, binom(j, i)});
    mac_next = ((j - i) & 3'd1) != 3'd0 ? acc - prod : acc + prod;
    signed_mag = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    midsum = SumW'($signed(store[0])) + SumW'($signed(store[1]));
  end

  assign busy = (state != S_IDLE);
  assign div_go = (state == S_DIV);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      held_duration <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          if (empty_req) begin
            count <= '0;
            strobe <= 1'b1; coefficient <= '0; order <= '0;
            final_res <= 1'b1; zero_duration <= 1'b0; saturated <= 1'b0;
          end else begin
            if (count < CntW'(MaxPoints)) begin
              store[count[IdxW-1:0]] <= point;
            end
            if (last) begin
              held_duration <= duration;
              count <= '0;
              n <= (count < CntW'(MaxPoints)) ? count[IdxW-1:0]
                                               : IdxW'(MaxPoints - 1);
              mid_mode <= (count == CntW'(1)) && (duration == 32'd0);
              j <= '0; i <= '0; acc <= '0;
              state <= S_MAC;
            end else if (count < CntW'(MaxPoints)) begin
              count <= count + CntW'(1);
            end
          end
        end
        // inner sum over i <= j
        S_MAC: begin
          acc <= mac_next;
          if (i == j) state <= S_OUTB;
          else i <= i + IdxW'(1);
        end
        S_OUTB: begin
          acc <= prod;
          neg <= prod < 0;
          mag <= prod < 0 ? MagW'(-prod) : MagW'(prod);
          k <= '0;
          if (j == '0 || held_duration == 32'd0) state <= S_EMIT;
          else state <= S_DIV;
        end
        S_DIV: state <= S_WAIT;
        S_WAIT: if (div_done) begin
          mag <= div_q;
          if (k + IdxW'(1) == j) state <= S_EMIT;
          else begin
            k <= k + IdxW'(1);
            state <= S_DIV;
          end
        end
        S_EMIT: begin
          strobe <= 1'b1;
          order <= j;
          final_res <= (j == n);
          zero_duration <= (held_duration == 32'd0) && !mid_mode;
          saturated <= 1'b0;
          priority if (mid_mode) begin
            if (j == '0) coefficient <= midsum >= 0 ? 32'((midsum + 1) >>> 1)
                                                    : 32'(-((-midsum + 1) >>> 1));
            else coefficient <= '0;
          end else if (j != '0 && held_duration == 32'd0) begin
            if (acc > 0) begin coefficient <= 32'h7fffffff; saturated <= 1'b1; end
            else if (acc < 0) begin coefficient <= 32'h80000000; saturated <= 1'b1; end
            else coefficient <= '0;
          end else begin
            if (signed_mag > SumW'(32'sh7fffffff)) begin
              coefficient <= 32'h7fffffff; saturated <= 1'b1;
            end else if (signed_mag < -SumW'(33'sh080000000)) begin
              coefficient <= 32'h80000000; saturated <= 1'b1;
            end else coefficient <= signed_mag[31:0];
          end
          if (j == n) state <= S_IDLE;
          else begin
            j <= j + IdxW'(1); i <= '0; acc <= '0;
            state <= S_MAC;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/bezier_to_power_basis_tb.sv =====
// ---------------------------------------------------------------------------
// bezier_to_power_basis_tb
// Self-checking bench for the Bezier to power-basis converter: directed
// curves (extremes, empty, single point, zero duration, excess points) and
// then random curves, checked against a local predictor or fixed values.
// ---------------------------------------------------------------------------
module bezier_to_power_basis_tb;
  import bzp_pkg::*;

  typedef struct packed {
    logic [31:0] coefficient;
    logic [2:0]  order;
    logic        final_res;
    logic        zero_duration;
    logic        saturated;
  } coef_t;

  typedef struct {
    logic [31:0] point;
    logic [31:0] duration;
    logic        last;
    logic        empty_req;
    logic        typed;
    logic [31:0] typed_coef;
  } row_t;

  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;
  localparam longint unsigned MagCap = 64'd1 << 46;
  localparam longint Fact [8] = '{1, 1, 2, 6, 24, 120, 720, 5040};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] point = '0;
  logic        [31:0] duration = '0;
  logic               last = 1'b0;
  logic               empty_req = 1'b0;
  logic               strobe;
  logic signed [31:0] coefficient;
  logic        [2:0]  order;
  logic               final_res;
  logic               zero_duration;
  logic               saturated;

  coef_t       coef_q [$];
  row_t        rows [$];
  logic [31:0] stored_pts [8];
  int          stored_cnt = 0;
  int          mismatches = 0;
  int          sent = 0;
  bit          no_gaps = 1'b0;

  bezier_to_power_basis DUT (.*);

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint binomial(int n, int k);
    return Fact[n] / (Fact[k] * Fact[n - k]);
  endfunction

  function automatic longint clip(longint v, ref logic sat);
    if (v > QMax) begin
      sat = 1'b1;
      return QMax;
    end
    if (v < QMin) begin
      sat = 1'b1;
      return QMin;
    end
    return v;
  endfunction

  // s * (65536 / d)^j, rounded half away from zero at every step
  function automatic longint scale_by_duration(longint s, logic [31:0] d, int j);
    bit              neg;
    longint unsigned mag;
    neg = s < 0;
    mag = neg ? longint'(-s) : s;
    for (int k = 0; k < j; k++) begin
      mag = (mag * 65536 + longint'(d / 2)) / longint'(d);
      if (mag > MagCap) mag = MagCap;
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  // update the point store and queue the coefficients a request causes
  function automatic void predict_coefs(logic [31:0] p, logic [31:0] d, logic l, logic e);
    longint xs [8];
    longint s, m;
    int     cnt, n;
    logic   zd, sat;
    if (e) begin
      stored_cnt = 0;
      coef_q.push_back('{32'd0, 3'd0, 1'b1, 1'b0, 1'b0});
      return;
    end
    if (stored_cnt < MaxPoints) begin
      stored_pts[stored_cnt] = p;
      stored_cnt++;
    end
    if (!l) return;
    cnt = stored_cnt;
    stored_cnt = 0;
    for (int i = 0; i < cnt; i++) xs[i] = longint'(signed'(stored_pts[i]));
    // two points and no duration: midpoint and flat slope
    if (cnt == 2 && d == 0) begin
      s = xs[0] + xs[1];
      m = s >= 0 ? (s + 1) / 2 : -((-s + 1) / 2);
      coef_q.push_back('{m[31:0], 3'd0, 1'b0, 1'b0, 1'b0});
      coef_q.push_back('{32'd0, 3'd1, 1'b1, 1'b0, 1'b0});
      return;
    end
    n = cnt - 1;
    zd = (d == 0);
    for (int j = 0; j <= n; j++) begin
      s = 0;
      sat = 1'b0;
      for (int i = 0; i <= j; i++)
        s += ((j - i) % 2 == 1) ? -binomial(j, i) * xs[i] : binomial(j, i) * xs[i];
      s *= binomial(n, j);
      if (j == 0) m = clip(s, sat);
      else if (zd) begin
        sat = (s != 0);
        m = s > 0 ? QMax : (s < 0 ? QMin : 0);
      end else m = clip(scale_by_duration(s, d, j), sat);
      coef_q.push_back('{m[31:0], 3'(j), j == n, zd, sat});
    end
  endfunction

  // issue one request and hold it until accepted; optional idle burst first
  task automatic send_request(row_t r);
    if (!no_gaps && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    start     <= 1'b1;
    point     <= r.point;
    duration  <= r.duration;
    last      <= r.last;
    empty_req <= r.empty_req;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_coefs(r.point, r.duration, r.last, r.empty_req);
    if (r.typed) begin
      // a single point with no duration carries the zero-duration flag
      coef_q.pop_back();
      coef_q.push_back('{r.typed_coef, 3'd0, 1'b1,
                         r.last && !r.empty_req && (r.duration == 32'd0), 1'b0});
    end
    sent++;
  endtask

  function automatic void add_row(logic [31:0] p, logic [31:0] d, logic l, logic e,
                                  logic t = 1'b0, logic [31:0] tc = '0);
    rows.push_back('{p, d, l, e, t, tc});
  endfunction

  function automatic logic [31:0] rand_point();
    if ($urandom_range(0, 1)) return $urandom;
    return 32'($urandom_range(0, 32'h3ffff)) - 32'h20000;
  endfunction

  function automatic logic [31:0] rand_duration();
    case ($urandom_range(0, 19))
      0, 1, 2:     return 32'd0;
      3, 4, 5, 6:  return 32'h0001_0000;
      7, 8, 9, 10, 11, 12: return $urandom_range(32'h4000, 32'h40000);
      default:     return $urandom;
    endcase
  endfunction

  // result checking
  always @(posedge clk) begin
    coef_t got, want;
    if (!rst && strobe) begin
      got = '{coefficient, order, final_res, zero_duration, saturated};
      if (coef_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected coefficient %h order %0d", coefficient, order);
      end else begin
        want = coef_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected coef %h ord %0d fin %b zd %b sat %b, got %h %0d %b %b %b",
                     want.coefficient, want.order, want.final_res, want.zero_duration,
                     want.saturated, got.coefficient, got.order, got.final_res,
                     got.zero_duration, got.saturated);
        end
      end
    end
  end

  // stimulus
  initial begin
    int size;
    logic [31:0] d;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // empty curve, single extremes, two points with and without duration
    add_row(32'h1234_5678, 32'd0, 1'b0, 1'b1, 1'b1, 32'd0);
    add_row(32'h7fff_ffff, 32'hffff_ffff, 1'b1, 1'b0, 1'b1, 32'h7fff_ffff);
    add_row(32'h8000_0000, 32'd0, 1'b1, 1'b0, 1'b1, 32'h8000_0000);
    add_row(32'h7fff_ffff, 32'd0, 1'b0, 1'b0);
    add_row(32'h7fff_ffff, 32'd0, 1'b1, 1'b0);
    add_row(32'h8000_0000, 32'd0, 1'b0, 1'b0);
    add_row(32'h7fff_ffff, 32'h0001_0000, 1'b1, 1'b0);
    // three points, zero duration: order 1 sums to zero, order 2 saturates
    add_row(32'h0001_0000, 32'd0, 1'b0, 1'b0);
    add_row(32'h0001_0000, 32'd0, 1'b0, 1'b0);
    add_row(32'h0003_0000, 32'd0, 1'b1, 1'b0);
    // points then an empty request discards them
    add_row(32'h0005_0000, 32'd0, 1'b0, 1'b0);
    add_row(32'h0000_0000, 32'd0, 1'b0, 1'b1, 1'b1, 32'd0);
    // eight points, two excess ones ignored, tiny duration saturates
    for (int i = 0; i < 10; i++)
      add_row(i[0] ? 32'h7fff_ffff : 32'h8000_0000, 32'd1, i == 9, 1'b0);
    foreach (rows[i]) send_request(rows[i]);
    // random curves, well-formed mostly, with a few broken by an empty request
    while (sent < 200) begin
      no_gaps = sent > 160;
      if ($urandom_range(0, 19) == 0) begin
        send_request('{rand_point(), $urandom, $urandom_range(0, 1), 1'b1, 1'b0, '0});
        continue;
      end
      case ($urandom_range(0, 19))
        0:       size = $urandom_range(9, 11);
        1, 2, 3, 4, 5: size = $urandom_range(5, 8);
        default: size = $urandom_range(1, 4);
      endcase
      d = rand_duration();
      for (int i = 0; i < size; i++)
        send_request('{rand_point(), (i == size - 1) ? d : $urandom, i == size - 1,
                       1'b0, 1'b0, '0});
    end
    start <= 1'b0;
    while (coef_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  // watchdog
  initial begin
    #24_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
